// ===== hdl/agsp_pkg.sv =====
// ============================================================================
// agsp_pkg: shared types and constants for the graymap stream parser
// Holds the character codes, field widths, the result kind codes and the
// queue word that the front end hands to the back end.
// ============================================================================
`default_nettype none

package agsp_pkg;

  // Image limits and field widths.
  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned PixelBits = 16;
  localparam int unsigned DimW      = 13;
  localparam int unsigned DepthW    = 16;
  localparam int unsigned AccW      = 32;
  localparam int unsigned KindW     = 2;

  // Queue between front and back end.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // Scaling divider: one quotient bit per cycle.
  localparam int unsigned DivSteps = 16;
  localparam int unsigned StepW    = 4;

  // Pixel mask applied to every emitted pixel value.
  localparam logic [DepthW-1:0] PixMask = DepthW'((32'd1 << PixelBits) - 32'd1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DEPTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DEPTH = 1'b1;

  // Character codes.
  localparam logic [7:0] CharP    = 8'h50;
  localparam logic [7:0] CharTwo  = 8'h32;
  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharSp   = 8'h20;
  localparam logic [7:0] CharTab  = 8'h09;
  localparam logic [7:0] CharVt   = 8'h0B;
  localparam logic [7:0] CharFf   = 8'h0C;
  localparam logic [7:0] CharCr   = 8'h0D;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } item_kind_e;

  // One queued result request. For a pixel that needs rescaling, value holds
  // the saturated number and divisor the declared depth; otherwise value
  // holds the raw low bits of the number.
  typedef struct packed {
    item_kind_e          kind;
    logic [DimW-1:0]     width;
    logic [DimW-1:0]     height;
    logic [DepthW-1:0]   depth;
    logic [AccW-1:0]     value;
    logic [AccW-1:0]     divisor;
    logic                scale;
    logic                last;
  } entry_t;

  // Whitespace test: space, tab, newline, vertical tab, form feed, return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSp) || (c == CharTab) || (c == CharLf) ||
           (c == CharVt) || (c == CharFf) || (c == CharCr);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/agsp_front.sv =====
// ============================================================================
// agsp_front: byte parser of the graymap stream parser
// Takes one byte per cycle while the queue has room, tracks the header and
// pixel grid, and queues header, pixel and error words for the back end.
// ============================================================================
`default_nettype none

module agsp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         first_byte_i,
  input  logic                         end_of_input_i,
  input  logic [agsp_pkg::DepthW-1:0]  min_depth_i,
  input  logic [agsp_pkg::DepthW-1:0]  max_depth_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output agsp_pkg::entry_t             q_entry_o
);
  import agsp_pkg::*;

  typedef enum logic [7:0] {
    PH_MAG0 = 8'b0000_0001,
    PH_MAG1 = 8'b0000_0010,
    PH_WID  = 8'b0000_0100,
    PH_HGT  = 8'b0000_1000,
    PH_DEP  = 8'b0001_0000,
    PH_PIX  = 8'b0010_0000,
    PH_DONE = 8'b0100_0000,
    PH_ERR  = 8'b1000_0000
  } phase_e;

  phase_e            phase_q, phase_d, ph_e;
  logic [AccW-1:0]   acc_q, acc_d, acc_e;
  logic              ovf_q, ovf_d, ovf_e;
  logic              dig_q, dig_d, dig_e;
  logic              com_q, com_d, com_e;
  logic [DimW-1:0]   wid_q, wid_d, wid_e;
  logic [DimW-1:0]   hgt_q, hgt_d, hgt_e;
  logic [AccW-1:0]   dd_q, dd_d, dd_e;
  logic [DimW-1:0]   col_q, col_d, col_e;
  logic [DimW-1:0]   row_q, row_d, row_e;

  logic              accept;
  logic              is_digit;
  logic [3:0]        dval;
  logic [AccW+3:0]   acc_x10;
  logic [AccW-1:0]   acc_upd;
  logic              ovf_upd;
  logic [AccW-1:0]   num_v;
  logic [DepthW-1:0] kept_new;
  logic [DepthW-1:0] kept_old;
  logic              scale;
  logic [DimW-1:0]   col_inc;
  logic              col_wrap;
  logic [DimW-1:0]   row_inc;
  logic              pix_last;
  logic              hdr_last;
  logic              active;
  logic              fail;
  logic              fin;
  logic              hash;
  logic              emit;
  entry_t            entry;

  // A byte is taken whenever the queue has room.
  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept && emit;
  assign q_entry_o  = entry;

  // A first byte restarts parsing before the byte itself is looked at.
  assign ph_e  = first_byte_i ? PH_MAG0 : phase_q;
  assign acc_e = first_byte_i ? '0 : acc_q;
  assign ovf_e = first_byte_i ? 1'b0 : ovf_q;
  assign dig_e = first_byte_i ? 1'b0 : dig_q;
  assign com_e = first_byte_i ? 1'b0 : com_q;
  assign wid_e = first_byte_i ? '0 : wid_q;
  assign hgt_e = first_byte_i ? '0 : hgt_q;
  assign dd_e  = first_byte_i ? '0 : dd_q;
  assign col_e = first_byte_i ? '0 : col_q;
  assign row_e = first_byte_i ? '0 : row_q;

  // Decimal accumulation with a sticky overflow beyond 32 bits.
  assign is_digit = (data_byte_i >= CharZero) && (data_byte_i <= CharNine);
  assign dval     = 4'(data_byte_i - CharZero);
  assign acc_x10  = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0} + (AccW+4)'(dval);
  assign acc_upd  = is_digit ? acc_x10[AccW-1:0] : acc_e;
  assign ovf_upd  = is_digit ? (ovf_e || (|acc_x10[AccW+3:AccW])) : ovf_e;
  assign num_v    = ovf_upd ? '1 : acc_upd;

  // Kept depth is the declared depth clamped to max_depth.
  assign kept_new = (num_v > {16'b0, max_depth_i}) ? max_depth_i : num_v[DepthW-1:0];
  assign kept_old = (dd_e > {16'b0, max_depth_i}) ? max_depth_i : dd_e[DepthW-1:0];
  assign scale    = dd_e > {16'b0, max_depth_i};

  // Pixel grid position after this pixel.
  assign col_inc  = col_e + 1'b1;
  assign col_wrap = col_inc >= wid_e;
  assign row_inc  = col_wrap ? (row_e + 1'b1) : row_e;
  assign pix_last = row_inc >= hgt_e;
  assign hdr_last = (wid_e == '0) || (hgt_e == '0);

  // Byte classification, number completion and fault handling.
  always_comb begin
    phase_d = ph_e;
    acc_d   = acc_e;
    ovf_d   = ovf_e;
    dig_d   = dig_e;
    com_d   = com_e;
    wid_d   = wid_e;
    hgt_d   = hgt_e;
    dd_d    = dd_e;
    col_d   = col_e;
    row_d   = row_e;
    fail    = 1'b0;
    fin     = 1'b0;
    hash    = 1'b0;
    emit    = 1'b0;
    entry   = '0;
    active  = !((ph_e == PH_DONE) || (ph_e == PH_ERR));

    if (active) begin
      if (ph_e == PH_MAG0) begin
        if (data_byte_i != CharP) fail = 1'b1;
        else phase_d = PH_MAG1;
      end else if (ph_e == PH_MAG1) begin
        if (data_byte_i != CharTwo) fail = 1'b1;
        else phase_d = PH_WID;
      end else if (com_e) begin
        if (data_byte_i == CharLf) com_d = 1'b0;
      end else if (is_digit) begin
        acc_d = acc_upd;
        ovf_d = ovf_upd;
        dig_d = 1'b1;
        fin   = end_of_input_i;
      end else if (is_space(data_byte_i)) begin
        fin = dig_e;
      end else if (data_byte_i == CharHash) begin
        fin  = dig_e;
        hash = 1'b1;
      end else begin
        fail = 1'b1;
      end

      // A number has ended: store it or turn it into a result.
      if (fin) begin
        acc_d = '0;
        ovf_d = 1'b0;
        dig_d = 1'b0;
        if ((ph_e == PH_WID) || (ph_e == PH_HGT)) begin
          if (num_v > 32'(MaxDim)) begin
            fail = 1'b1;
          end else if (ph_e == PH_WID) begin
            wid_d   = num_v[DimW-1:0];
            phase_d = PH_HGT;
          end else begin
            hgt_d   = num_v[DimW-1:0];
            phase_d = PH_DEP;
          end
        end else if (ph_e == PH_DEP) begin
          dd_d = num_v;
          if (num_v < {16'b0, min_depth_i}) begin
            fail = 1'b1;
          end else begin
            col_d         = '0;
            row_d         = '0;
            emit          = 1'b1;
            entry.kind    = KIND_HEADER;
            entry.width   = wid_e;
            entry.height  = hgt_e;
            entry.depth   = kept_new;
            entry.last    = hdr_last;
            phase_d       = hdr_last ? PH_DONE : PH_PIX;
          end
        end else begin
          col_d         = col_wrap ? '0 : col_inc;
          row_d         = row_inc;
          emit          = 1'b1;
          entry.kind    = KIND_PIXEL;
          entry.width   = wid_e;
          entry.height  = hgt_e;
          entry.depth   = kept_old;
          entry.value   = scale ? num_v : acc_upd;
          entry.divisor = dd_e;
          entry.scale   = scale;
          entry.last    = pix_last;
          if (pix_last) phase_d = PH_DONE;
        end
      end

      // A comment may start only before the width, the depth or a pixel.
      if (hash && !fail && (phase_d != PH_DONE)) begin
        if ((phase_d == PH_WID) || (phase_d == PH_DEP) || (phase_d == PH_PIX)) begin
          com_d = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end

      // Input that ends before the image is complete.
      if (!fail && end_of_input_i && (phase_d != PH_DONE)) fail = 1'b1;

      // Any fault replaces whatever this byte produced.
      if (fail) begin
        phase_d    = PH_ERR;
        com_d      = 1'b0;
        emit       = 1'b1;
        entry      = '0;
        entry.kind = KIND_ERROR;
        entry.last = 1'b1;
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAG0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      dig_q   <= 1'b0;
      com_q   <= 1'b0;
      wid_q   <= '0;
      hgt_q   <= '0;
      dd_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      dig_q   <= dig_d;
      com_q   <= com_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      dd_q    <= dd_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // After a fault nothing is emitted until a new image starts.
  a_quiet_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ERR && !first_byte_i) |-> !q_push_o)
    else $error("agsp_front: word pushed after an error without restart");

endmodule

`default_nettype wire

// ===== hdl/agsp_fifo.sv =====
// ============================================================================
// agsp_fifo: short queue between parser and scaler
// Holds up to QDepth result requests so that parsing and scaling stall
// independently of each other.
// ============================================================================
`default_nettype none

module agsp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  agsp_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  output agsp_pkg::entry_t entry_o,
  input  logic             pop_i
);
  import agsp_pkg::*;

  entry_t           slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = slot_q[rd_ptr_q];

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("agsp_fifo: push into a full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("agsp_fifo: pop from an empty queue");

endmodule

`default_nettype wire

// ===== hdl/agsp_back.sv =====
// ============================================================================
// agsp_back: result builder and pixel scaler
// Pops queued words, rescales deep pixels with a multiply followed by a
// bit-serial divide, and presents results through an output register.
// ============================================================================
`default_nettype none

module agsp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  agsp_pkg::entry_t            q_entry_i,
  output logic                        q_pop_o,
  input  logic [agsp_pkg::DepthW-1:0] max_depth_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [agsp_pkg::KindW-1:0]  item_kind_o,
  output logic [agsp_pkg::DimW-1:0]   image_width_o,
  output logic [agsp_pkg::DimW-1:0]   image_height_o,
  output logic [agsp_pkg::DepthW-1:0] gray_depth_o,
  output logic [agsp_pkg::DepthW-1:0] pixel_value_o,
  output logic                        last_item_o
);
  import agsp_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [DepthW-1:0] depth;
    logic [DepthW-1:0] pixel;
    logic              last;
  } result_t;

  bstate_e                  state_q, state_d;
  logic                     out_valid_q, out_valid_d;
  result_t                  out_q;
  entry_t                   hold_q;
  logic [AccW-1:0]          rem_q;
  logic [DivSteps-1:0]      lo_q;
  logic [StepW-1:0]         step_q;

  logic                     out_free;
  logic                     need_div;
  logic                     load_direct;
  logic                     load_div;
  logic                     capture;
  logic [DepthW-1:0]        direct_pix;
  logic [AccW+DepthW-1:0]   prod;
  logic [AccW:0]            trial;
  logic                     trial_ge;

  assign out_free = !out_valid_q || !out_stall_i;

  // Only a rescaled pixel below its declared depth needs the divider; the rest
  // of the rescaled pixels saturate at max_depth.
  assign need_div   = (q_entry_i.kind == KIND_PIXEL) && q_entry_i.scale &&
                      (q_entry_i.value < q_entry_i.divisor);
  assign direct_pix = q_entry_i.scale ? max_depth_i : q_entry_i.value[DepthW-1:0];

  // value * max_depth; the quotient is known to fit in DivSteps bits.
  assign prod     = hold_q.value * max_depth_i;
  assign trial    = {rem_q, lo_q[DivSteps-1]};
  assign trial_ge = trial >= {1'b0, hold_q.divisor};

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    load_direct = 1'b0;
    load_div    = 1'b0;
    capture     = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          if (need_div) begin
            q_pop_o = 1'b1;
            capture = 1'b1;
            state_d = B_MUL;
          end else if (out_free) begin
            q_pop_o     = 1'b1;
            load_direct = 1'b1;
          end
        end
      end
      B_MUL: state_d = B_DIV;
      B_DIV: begin
        if (step_q == StepW'(DivSteps - 1)) state_d = B_OUT;
      end
      B_OUT: begin
        if (out_free) begin
          load_div = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_direct || load_div) out_valid_d = 1'b1;
    else if (!out_stall_i)       out_valid_d = 1'b0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == B_MUL)      step_q <= '0;
      else if (state_q == B_DIV) step_q <= step_q + 1'b1;
    end
  end

  // Divider datapath: restoring division, one quotient bit per cycle,
  // quotient bits shift into the low word as dividend bits leave it.
  always_ff @(posedge clk_i) begin
    if (capture) hold_q <= q_entry_i;
    if (state_q == B_MUL) begin
      rem_q <= prod[AccW+DepthW-1:DepthW];
      lo_q  <= prod[DivSteps-1:0];
    end else if (state_q == B_DIV) begin
      rem_q <= trial_ge ? AccW'(trial - {1'b0, hold_q.divisor}) : trial[AccW-1:0];
      lo_q  <= {lo_q[DivSteps-2:0], trial_ge};
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load_direct) begin
      out_q.kind   <= q_entry_i.kind;
      out_q.width  <= q_entry_i.width;
      out_q.height <= q_entry_i.height;
      out_q.depth  <= q_entry_i.depth;
      out_q.pixel  <= direct_pix & PixMask;
      out_q.last   <= q_entry_i.last;
    end else if (load_div) begin
      out_q.kind   <= hold_q.kind;
      out_q.width  <= hold_q.width;
      out_q.height <= hold_q.height;
      out_q.depth  <= hold_q.depth;
      out_q.pixel  <= lo_q & PixMask;
      out_q.last   <= hold_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign item_kind_o    = out_q.kind;
  assign image_width_o  = out_q.width;
  assign image_height_o = out_q.height;
  assign gray_depth_o   = out_q.depth;
  assign pixel_value_o  = out_q.pixel;
  assign last_item_o    = out_q.last;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (rem_q < hold_q.divisor))
    else $error("agsp_back: partial remainder not below divisor");

  // A divided pixel lies below max_depth, or is zero when max_depth is zero.
  a_quot_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_OUT) |-> ((lo_q < max_depth_i) || (lo_q == '0)))
    else $error("agsp_back: scaled pixel out of range");

endmodule

`default_nettype wire

// ===== hdl/ascii_graymap_stream_parser.sv =====
// ============================================================================
// ascii_graymap_stream_parser: plain-text graymap parser, top level
// Parses "P2" graymap text one byte per word and emits header, pixel and
// error results; holds the min_depth and max_depth registers.
// ============================================================================
// Usage:
//   Input channel: one text byte per word with first_byte (starts a new
//   image) and end_of_input (no byte follows). The parser takes one byte
//   per cycle while the result queue has room; in_stall_o rises when the
//   queue is full.
//   Output channel: at most one result per byte (header, pixel or error).
//   A result that needs no rescaling passes through the queue and the output
//   register. A pixel of an image deeper than max_depth that lies below the
//   declared depth goes through a multiply step and a bit-serial divide in
//   the scaler, which pops no new word before its result loads; the divider
//   sets the rate for such images, else one byte per cycle, queue allowing.
//   When out_stall_i is high the result register holds its word, the queue
//   fills and then the input stalls.
//   Configuration: writes of min_depth (index 0) and max_depth (index 1)
//   are always accepted and must only happen while the block is idle.
//   Reset: the parser waits for the first magic byte, the queue and the
//   output register are empty, min_depth is 1 and max_depth is 255.
// ============================================================================
`default_nettype none

module ascii_graymap_stream_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         first_byte_i,
  input  logic                         end_of_input_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [agsp_pkg::KindW-1:0]   item_kind_o,
  output logic [agsp_pkg::DimW-1:0]    image_width_o,
  output logic [agsp_pkg::DimW-1:0]    image_height_o,
  output logic [agsp_pkg::DepthW-1:0]  gray_depth_o,
  output logic [agsp_pkg::DepthW-1:0]  pixel_value_o,
  output logic                         last_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [agsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [agsp_pkg::DepthW-1:0]  cfg_data_i
);
  import agsp_pkg::*;

  logic [DepthW-1:0] min_depth_q;
  logic [DepthW-1:0] max_depth_q;
  logic              q_full;
  logic              q_push;
  logic              q_valid;
  logic              q_pop;
  entry_t            push_entry;
  entry_t            pop_entry;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_depth_q <= DepthW'(1);
      max_depth_q <= DepthW'(255);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_DEPTH: min_depth_q <= cfg_data_i;
        CFG_MAX_DEPTH: max_depth_q <= cfg_data_i;
      endcase
    end
  end

  // Byte parser.
  agsp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .end_of_input_i (end_of_input_i),
    .min_depth_i    (min_depth_q),
    .max_depth_i    (max_depth_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (push_entry)
  );

  // Result queue.
  agsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .pop_i   (q_pop)
  );

  // Scaler and output register.
  agsp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (pop_entry),
    .q_pop_o        (q_pop),
    .max_depth_i    (max_depth_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .gray_depth_o   (gray_depth_o),
    .pixel_value_o  (pixel_value_o),
    .last_item_o    (last_item_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the plain-text graymap stream parser
// Feeds "P2" graymap text one byte per word, predicts every header, pixel
// and error result in a small tracker class, and compares each result word
// that the block hands out, under several depth register settings and
// several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import agsp_pkg::*;

  localparam int unsigned DIM_LIMIT   = 4096;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SEGMENT_LEN = 150;

  // Character codes used by the parser and the text generator.
  localparam logic [7:0] ASCII_P    = 8'h50;
  localparam logic [7:0] ASCII_TWO  = 8'h32;
  localparam logic [7:0] ASCII_HASH = 8'h23;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_SP   = 8'h20;
  localparam logic [7:0] ASCII_TAB  = 8'h09;
  localparam logic [7:0] ASCII_VT   = 8'h0B;
  localparam logic [7:0] ASCII_FF   = 8'h0C;
  localparam logic [7:0] ASCII_CR   = 8'h0D;

  typedef enum int unsigned {
    PH_MAGIC0, PH_MAGIC1, PH_WIDTH, PH_HEIGHT, PH_DEPTH, PH_PIXELS, PH_DONE, PH_ERROR
  } parse_phase_e;

  typedef struct {
    item_kind_e        kind;
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [DepthW-1:0] depth;
    logic [DepthW-1:0] pixel;
    logic              last;
  } graymap_item_t;

  // Tracks the parse of the byte stream and holds the results still due.
  class graymap_tracker;
    logic [15:0]   min_depth;
    logic [15:0]   max_depth;
    parse_phase_e  phase;
    logic [31:0]   acc;
    logic [31:0]   width;
    logic [31:0]   height;
    logic [31:0]   depth_decl;
    logic [31:0]   col;
    logic [31:0]   row;
    bit            acc_ovf;
    bit            digits;
    bit            in_comment;
    graymap_item_t items_due[$];
    int unsigned   failures;
    int unsigned   checked;

    function new();
      min_depth = 16'd1;
      max_depth = 16'd255;
      failures  = 0;
      checked   = 0;
      restart();
    endfunction

    function void restart();
      phase      = PH_MAGIC0;
      acc        = '0;
      acc_ovf    = 1'b0;
      digits     = 1'b0;
      in_comment = 1'b0;
      width      = '0;
      height     = '0;
      depth_decl = '0;
      col        = '0;
      row        = '0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx == CFG_MIN_DEPTH) min_depth = val;
      else max_depth = val;
    endfunction

    function void push_item(item_kind_e kind, logic [31:0] pix, bit last);
      graymap_item_t it;
      logic [31:0] kept;
      bit is_err;
      is_err   = (kind == KIND_ERROR);
      kept     = (depth_decl > max_depth) ? 32'(max_depth) : depth_decl;
      it.kind   = kind;
      it.width  = is_err ? '0 : width[DimW-1:0];
      it.height = is_err ? '0 : height[DimW-1:0];
      it.depth  = is_err ? '0 : kept[DepthW-1:0];
      it.pixel  = pix[DepthW-1:0];
      it.last   = last;
      items_due.push_back(it);
    endfunction

    function void flag_error();
      phase      = PH_ERROR;
      in_comment = 1'b0;
      push_item(KIND_ERROR, '0, 1'b1);
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == ASCII_SP) || (c == ASCII_TAB) || (c == ASCII_LF) ||
             (c == ASCII_VT) || (c == ASCII_FF) || (c == ASCII_CR);
    endfunction

    // Ends the number being read; returns 1 when a result was produced.
    function bit close_number();
      logic [31:0] v;
      logic [31:0] low;
      logic [63:0] q;
      bit ovf;
      bit last;
      v       = acc_ovf ? 32'hFFFF_FFFF : acc;
      ovf     = acc_ovf;
      low     = acc;
      acc     = '0;
      acc_ovf = 1'b0;
      digits  = 1'b0;
      if (phase == PH_WIDTH || phase == PH_HEIGHT) begin
        if (v > DIM_LIMIT) begin
          flag_error();
          return 1'b1;
        end
        if (phase == PH_WIDTH) begin
          width = v;
          phase = PH_HEIGHT;
        end else begin
          height = v;
          phase  = PH_DEPTH;
        end
        return 1'b0;
      end
      if (phase == PH_DEPTH) begin
        depth_decl = v;
        if (v < min_depth) begin
          flag_error();
          return 1'b1;
        end
        col = '0;
        row = '0;
        if (width == 0 || height == 0) begin
          phase = PH_DONE;
          push_item(KIND_HEADER, '0, 1'b1);
        end else begin
          phase = PH_PIXELS;
          push_item(KIND_HEADER, '0, 1'b0);
        end
        return 1'b1;
      end
      // Pixel: rescale deep images, otherwise keep the low bits.
      if (depth_decl > max_depth) begin
        q = (64'(v) * 64'(max_depth)) / 64'(depth_decl);
        if (ovf || q > max_depth) q = 64'(max_depth);
      end else begin
        q = 64'(low);
      end
      col  = col + 1;
      if (col >= width) begin
        col = '0;
        row = row + 1;
      end
      last = 1'b0;
      if (row >= height) begin
        phase = PH_DONE;
        last  = 1'b1;
      end
      push_item(KIND_PIXEL, q[31:0], last);
      return 1'b1;
    endfunction

    // Takes one accepted byte; returns 0 when the block ignores it.
    function bit accept_byte(logic [7:0] c, bit first, bit eoi);
      bit emitted;
      logic [7:0] want;
      logic [31:0] d;
      emitted = 1'b0;
      if (first) restart();
      if (phase == PH_DONE || phase == PH_ERROR) return 1'b0;
      if (phase == PH_MAGIC0 || phase == PH_MAGIC1) begin
        want = (phase == PH_MAGIC0) ? ASCII_P : ASCII_TWO;
        if (c != want) begin
          flag_error();
          return 1'b1;
        end
        phase = (phase == PH_MAGIC0) ? PH_MAGIC1 : PH_WIDTH;
      end else if (in_comment) begin
        if (c == ASCII_LF) in_comment = 1'b0;
      end else if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
        d = 32'(c - ASCII_ZERO);
        if (acc > (32'hFFFF_FFFF - d) / 32'd10) acc_ovf = 1'b1;
        acc    = acc * 32'd10 + d;
        digits = 1'b1;
        if (eoi) emitted = close_number();
      end else if (is_blank(c)) begin
        if (digits) emitted = close_number();
      end else if (c == ASCII_HASH) begin
        if (digits) emitted = close_number();
        if (phase == PH_ERROR || phase == PH_DONE) return 1'b1;
        // A comment may only precede the width, the depth or a pixel.
        if (phase != PH_WIDTH && phase != PH_DEPTH && phase != PH_PIXELS) begin
          if (emitted) void'(items_due.pop_back());
          flag_error();
          return 1'b1;
        end
        in_comment = 1'b1;
      end else begin
        flag_error();
        return 1'b1;
      end
      if (phase == PH_ERROR) return 1'b1;
      // An early end replaces whatever this byte completed with an error.
      if (eoi && phase != PH_DONE) begin
        if (emitted) void'(items_due.pop_back());
        flag_error();
      end
      return 1'b1;
    endfunction

    function void check_item(logic [KindW-1:0] kind, logic [DimW-1:0] w,
                             logic [DimW-1:0] h, logic [DepthW-1:0] dep,
                             logic [DepthW-1:0] pix, logic last);
      graymap_item_t exp;
      checked++;
      if (items_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d arrived with none due: kind %0d w %0d h %0d d %0d p %0d l %0d",
                   checked, kind, w, h, dep, pix, last);
        return;
      end
      exp = items_due.pop_front();
      if (kind !== KindW'(exp.kind) || w !== exp.width || h !== exp.height ||
          dep !== exp.depth || pix !== exp.pixel || last !== exp.last) begin
        failures++;
        if (failures <= 10) begin
          $display("result %0d expected: kind %0d w %0d h %0d d %0d p %0d l %0d",
                   checked, int'(exp.kind), exp.width, exp.height, exp.depth,
                   exp.pixel, exp.last);
          $display("result %0d actual:   kind %0d w %0d h %0d d %0d p %0d l %0d",
                   checked, kind, w, h, dep, pix, last);
        end
      end
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i    = '0;
  logic                  first_byte_i   = 1'b0;
  logic                  end_of_input_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [KindW-1:0]      item_kind_o;
  logic [DimW-1:0]       image_width_o;
  logic [DimW-1:0]       image_height_o;
  logic [DepthW-1:0]     gray_depth_o;
  logic [DepthW-1:0]     pixel_value_o;
  logic                  last_item_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i    = '0;
  logic [DepthW-1:0]     cfg_data_i     = '0;

  graymap_tracker tracker;
  logic [7:0]     text_q[$];
  int unsigned    in_idle_pct  = 15;
  int unsigned    out_idle_pct = 49;
  int unsigned    bytes_used   = 0;
  int unsigned    cycle_count  = 0;
  int unsigned    hold_left    = 0;
  logic           hold_go      = 1'b0;
  logic           hold_seen    = 1'b0;

  always #10 clk_i = ~clk_i;

  ascii_graymap_stream_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .gray_depth_o   (gray_depth_o),
    .pixel_value_o  (pixel_value_o),
    .last_item_o    (last_item_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Receiver: checks each accepted result word and drives the stall, with
  // one long hold-off on request so the block fills up.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_item(item_kind_o, image_width_o, image_height_o,
                         gray_depth_o, pixel_value_o, last_item_o);
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen   <= hold_go;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ascii_graymap_stream_parser: mismatch");
      $finish;
    end
  end

  // Text building helpers: everything lands in text_q.
  function automatic void put(logic [7:0] c);
    text_q.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_num(logic [63:0] v);
    logic [7:0] digs[$];
    if ($urandom_range(0, 7) == 0) put(ASCII_ZERO);
    do begin
      digs.push_front(ASCII_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) text_q.push_back(digs[i]);
  endfunction

  function automatic void put_space();
    case ($urandom_range(0, 5))
      0:       put(ASCII_TAB);
      1:       put(ASCII_LF);
      2:       put(ASCII_VT);
      3:       put(ASCII_FF);
      4:       put(ASCII_CR);
      default: put(ASCII_SP);
    endcase
  endfunction

  // Separator between numbers; a comment only where one is legal.
  function automatic void put_sep(bit comment_ok);
    if (comment_ok && $urandom_range(0, 5) == 0) begin
      if ($urandom_range(0, 1) == 1) put_space();
      put(ASCII_HASH);
      repeat ($urandom_range(0, 4)) put(8'($urandom_range(8'h20, 8'h7E)));
      put(ASCII_LF);
      if ($urandom_range(0, 1) == 1) put_space();
    end else begin
      repeat ($urandom_range(1, 2)) put_space();
    end
  endfunction

  function automatic logic [63:0] pick_depth();
    logic [63:0] mn;
    logic [63:0] mx;
    mn = 64'(tracker.min_depth);
    mx = 64'(tracker.max_depth);
    case ($urandom_range(0, 9))
      0:       return mn;
      1:       return mx;
      2:       return (mx < 65535) ? mx + 1 : 64'd65535;
      3:       return 64'($urandom_range(mn[31:0], 65535));
      4:       return 64'd65535;
      5:       return {$urandom, $urandom};
      6:       return (mn > 0) ? mn - 1 : 64'd0;
      default: return 64'($urandom_range(mn[31:0], mx[31:0]));
    endcase
  endfunction

  function automatic logic [63:0] pick_pixel(logic [63:0] dep);
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return dep;
      2:       return dep + 64'($urandom_range(1, 70000));
      3:       return {$urandom, $urandom};
      4:       return 64'($urandom);
      default: return (dep >= 64'hFFFF_FFFF) ? 64'($urandom)
                                             : 64'($urandom_range(0, dep[31:0]));
    endcase
  endfunction

  function automatic void build_image(logic [63:0] w, logic [63:0] h, logic [63:0] dep);
    int unsigned npix;
    npix = (w <= 16 && h <= 16) ? int'(w * h) : 0;
    put(ASCII_P);
    put(ASCII_TWO);
    if ($urandom_range(0, 5) != 0) put_sep(1'b1);
    put_num(w);
    put_sep(1'b0);
    put_num(h);
    put_sep(1'b1);
    put_num(dep);
    repeat (npix) begin
      put_sep(1'b1);
      put_num(pick_pixel(dep));
    end
  endfunction

  // Offers one word and waits until the block takes it.
  task automatic send_byte(logic [7:0] c, bit first, bit eoi);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= c;
    first_byte_i   <= first;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o);
    if (tracker.accept_byte(c, first, eoi)) bytes_used++;
  endtask

  task automatic send_text(bit eoi_last);
    foreach (text_q[i])
      send_byte(text_q[i], i == 0, eoi_last && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  task automatic send_str(string s, bit eoi_last);
    put_str(s);
    send_text(eoi_last);
  endtask

  // Drains all results and lets the pipeline run dry.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.items_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_depths(logic [15:0] min_val, logic [15:0] max_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MIN_DEPTH;
    cfg_data_i  <= min_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(CFG_MIN_DEPTH, min_val);
    cfg_index_i <= CFG_MAX_DEPTH;
    cfg_data_i  <= max_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(CFG_MAX_DEPTH, max_val);
    cfg_valid_i <= 1'b0;
  endtask

  // One random image: mostly well formed, some cut short, corrupted or noise.
  task automatic random_text();
    logic [63:0] w;
    logic [63:0] h;
    int unsigned shape;
    int unsigned pos;
    w = 64'($urandom_range(1, 4));
    h = 64'($urandom_range(1, 3));
    case ($urandom_range(0, 19))
      0:       w = 0;
      1:       h = 0;
      2:       begin w = DIM_LIMIT; h = 0; end
      3:       begin w = 0; h = DIM_LIMIT; end
      4:       w = DIM_LIMIT + $urandom_range(1, 3);
      5:       h = DIM_LIMIT + 1;
      6:       w = {$urandom, $urandom};
      default: ;
    endcase
    shape = $urandom_range(0, 9);
    if (shape < 9) build_image(w, h, pick_depth());
    if (shape < 7) begin
      case ($urandom_range(0, 3))
        0, 1: send_text(1'b1);
        2: begin
          put_space();
          send_text(1'b1);
        end
        default: begin
          // Trailing bytes after the image are ignored until a new image.
          put_space();
          send_text(1'b0);
          repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
      endcase
    end else if (shape == 7) begin
      pos    = $urandom_range(1, text_q.size());
      text_q = text_q[0:pos-1];
      send_text(1'($urandom_range(0, 1)));
    end else if (shape == 8) begin
      pos         = $urandom_range(0, text_q.size() - 1);
      text_q[pos] = 8'($urandom_range(0, 255));
      send_text(1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      send_text(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_segment(logic [15:0] min_val, logic [15:0] max_val,
                             int unsigned in_pct, int unsigned out_pct, bit long_hold);
    int unsigned target;
    target = bytes_used + SEGMENT_LEN;
    settle();
    set_depths(min_val, max_val);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    if (long_hold) hold_go <= ~hold_go;
    while (bytes_used < target) random_text();
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed images under the reset depth settings.
    send_str("P2 2 1 255\n0 255", 1'b1);
    send_str("P2\n# gray\n3 1\n#c\n65535 #p\n0 65535\t32768", 1'b1);
    put_str("P21");
    put(ASCII_CR);
    put_str("1");
    put(ASCII_VT);
    put_str("7");
    put(ASCII_FF);
    put_str("5");
    put(ASCII_SP);
    send_text(1'b1);
    send_str("P2 -1 1 1 0", 1'b1);
    put(ASCII_P);
    put(8'hFF);
    send_text(1'b0);
    put(8'h00);
    send_text(1'b0);
    send_str("P3", 1'b1);
    send_str("P2 4097 1 1 0", 1'b1);
    send_str("P2 4096 0 255 ", 1'b1);
    send_str("P2 1 4097 9", 1'b1);
    send_str("P2 1 1 0 0", 1'b1);
    send_str("P2 1 2 255 4294967301 99999999999999999999", 1'b1);
    send_str("P2 1 1 1000 99999999999", 1'b1);
    send_str("P2 2 2 3 1 2", 1'b1);
    send_str("P2 1 1 1 #x", 1'b1);
    send_str("P2 3#c\n1 1 1 1 1", 1'b1);
    send_str("P2#w\n1 1#d\n9 3#x", 1'b0);
    send_byte(8'h7A, 1'b0, 1'b1);
    send_str("P2 5 ", 1'b0);
    send_str("P2 0 3 1\n", 1'b1);

    // Random images over several depth settings and idling patterns.
    run_segment(16'd1, 16'd65535, 15, 49, 1'b0);
    run_segment(16'd65535, 16'd65535, 15, 49, 1'b0);
    run_segment(16'd1, 16'd1, 49, 15, 1'b0);
    run_segment(16'd0, 16'd0, 49, 15, 1'b0);
    run_segment(16'd100, 16'd300, 0, 0, 1'b1);
    run_segment(16'($urandom_range(1, 300)), 16'($urandom_range(1, 65535)), 0, 0, 1'b0);

    settle();
    if (tracker.failures == 0 && tracker.items_due.size() == 0)
      $display("ascii_graymap_stream_parser: match");
    else
      $display("ascii_graymap_stream_parser: mismatch");
    $finish;
  end

endmodule
